// ===== design/pidaw_pkg.sv =====
package pidaw_pkg;

    localparam int CFG_IDX_W = 3;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_GAIN            = 3'd0;
    localparam t_cfg_idx CFG_INTEGRAL_TIME   = 3'd1;
    localparam t_cfg_idx CFG_DERIVATIVE_TIME = 3'd2;
    localparam t_cfg_idx CFG_OUTPUT_MIN      = 3'd3;
    localparam t_cfg_idx CFG_OUTPUT_MAX      = 3'd4;
    localparam t_cfg_idx CFG_DEAD_ZONE       = 3'd5;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_LOAD = 7'b0000010,
        S_MUL  = 7'b0000100,
        S_DIV  = 7'b0001000,
        S_FIN  = 7'b0010000,
        S_SUM  = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

    typedef enum logic [4:0] {
        PH_P   = 5'b00001,
        PH_I   = 5'b00010,
        PH_KD  = 5'b00100,
        PH_D   = 5'b01000,
        PH_INC = 5'b10000
    } t_phase;

endpackage

// ===== design/pid_controller_antiwindup.sv =====
// One shared add/subtract unit runs DATA_WIDTH shift-add steps per product and
// 2*DATA_WIDTH+16 restoring steps per quotient. A new word is accepted only in idle,
// after the last result has entered the output register; a finished result waits in
// the output register while the next word is accepted.
// Reset: synchronous, active low; restores register defaults and clears the controller state.
module pid_controller_antiwindup #(
    parameter int FRAC_BITS  = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_wr_en,
    input  logic [pidaw_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [DATA_WIDTH-1:0]             i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic signed [DATA_WIDTH-1:0]      i_target_value,
    input  logic signed [DATA_WIDTH-1:0]      i_measured_value,
    input  logic [DATA_WIDTH-1:0]             i_time_step,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [DATA_WIDTH-1:0]      o_drive_value
);
    import pidaw_pkg::*;

    localparam int DW = DATA_WIDTH;
    localparam int IW = DATA_WIDTH + 16;
    localparam int PW = DW + IW;
    localparam int CW = $clog2(PW);
    localparam logic [PW-1:0] LIM_DW = PW'(1) << (DW - 1);
    localparam logic [PW-1:0] LIM_IW = PW'(1) << (IW - 1);

    function automatic logic [DW-1:0] mag_dw(input logic [DW-1:0] v);
        return v[DW-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic logic [IW-1:0] mag_iw(input logic [IW-1:0] v);
        return v[IW-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic logic [DW-1:0] sat_dw(input logic [PW-1:0] m, input logic neg);
        if (neg) begin
            if (m > LIM_DW) return {1'b1, {(DW-1){1'b0}}};
            return ~m[DW-1:0] + 1'b1;
        end
        if (m >= LIM_DW) return {1'b0, {(DW-1){1'b1}}};
        return m[DW-1:0];
    endfunction

    function automatic logic [IW-1:0] sat_iw(input logic [PW-1:0] m, input logic neg);
        if (neg) begin
            if (m > LIM_IW) return {1'b1, {(IW-1){1'b0}}};
            return ~m[IW-1:0] + 1'b1;
        end
        if (m >= LIM_IW) return {1'b0, {(IW-1){1'b1}}};
        return m[IW-1:0];
    endfunction

    function automatic logic [DW-1:0] clamp_dw(input logic [DW:0] s);
        if (s[DW] != s[DW-1]) return s[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
        return s[DW-1:0];
    endfunction

    function automatic logic [IW-1:0] clamp_iw(input logic [IW:0] s);
        if (s[IW] != s[IW-1]) return s[IW] ? {1'b1, {(IW-1){1'b0}}} : {1'b0, {(IW-1){1'b1}}};
        return s[IW-1:0];
    endfunction

    logic [DW-1:0] r_gain;
    logic [DW-2:0] r_ti;
    logic [DW-2:0] r_td;
    logic [DW-1:0] r_out_min;
    logic [DW-1:0] r_out_max;
    logic [DW-2:0] r_dead_zone;

    t_state        r_state, n_state;
    t_phase        r_phase, n_phase;
    logic [IW-1:0] r_hi, n_hi;
    logic [DW-1:0] r_lo, n_lo;
    logic [IW-1:0] r_mcand, n_mcand;
    logic          r_neg, n_neg;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [DW-1:0] r_rem, n_rem;
    logic [DW-1:0] r_dvsr, n_dvsr;
    logic [DW-1:0] r_err, n_err;
    logic [DW-1:0] r_dt, n_dt;
    logic [DW-1:0] r_sum, n_sum;
    logic [IW-1:0] r_integ, n_integ;
    logic [DW-1:0] r_last_err, n_last_err;
    logic          r_first, n_first;
    logic          r_out_valid, n_out_valid;
    logic [DW-1:0] r_out_data, n_out_data;

    logic [IW:0]   add_a, add_b, add_res;
    logic          add_sub;
    logic [DW:0]   rem_sh;
    logic          div_ge;
    logic [PW-1:0] prod, prod_sh, prod_shl;
    logic [DW-1:0] res_dw;
    logic [IW-1:0] res_iw;
    logic [DW:0]   diff, diff_mag;
    logic          d_en, err_pos, err_neg, pushing;
    logic [DW-1:0] drive;

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_drive_value = r_out_data;

    // shared add/subtract unit
    assign rem_sh = {r_rem, r_hi[IW-1]};
    always_comb begin
        add_a   = '0;
        add_b   = '0;
        add_sub = 1'b0;
        case (r_state)
            S_MUL: begin
                add_a = {1'b0, r_hi};
                add_b = r_lo[0] ? {1'b0, r_mcand} : '0;
            end
            S_DIV: begin
                add_a   = (IW+1)'(rem_sh);
                add_b   = (IW+1)'(r_dvsr);
                add_sub = 1'b1;
            end
            default: begin
                add_sub = 1'b0;
            end
        endcase
        add_res = add_sub ? (add_a - add_b) : (add_a + add_b);
    end

    assign div_ge   = !add_res[IW];
    assign prod     = {r_hi, r_lo};
    assign prod_sh  = prod >> FRAC_BITS;
    assign prod_shl = {prod[PW-2:0], div_ge};
    assign res_dw   = sat_dw((r_phase == PH_P || r_phase == PH_KD) ? prod_sh : prod, r_neg);
    assign res_iw   = sat_iw(prod_sh, r_neg);
    assign diff     = {r_err[DW-1], r_err} - {r_last_err[DW-1], r_last_err};
    assign diff_mag = diff[DW] ? (~diff + 1'b1) : diff;
    assign d_en     = !r_first && (r_dt != '0);
    assign err_neg  = r_err[DW-1];
    assign err_pos  = !r_err[DW-1] && (r_err != '0);
    assign pushing  = ($signed(r_sum) > $signed(r_out_max) && err_pos)
                   || ($signed(r_sum) < $signed(r_out_min) && err_neg);

    always_comb begin
        if (mag_dw(r_sum) < {1'b0, r_dead_zone}) begin
            drive = '0;
        end else if ($signed(r_sum) < $signed(r_out_min)) begin
            drive = r_out_min;
        end else if ($signed(r_sum) > $signed(r_out_max)) begin
            drive = r_out_max;
        end else begin
            drive = r_sum;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_hi        = r_hi;
        n_lo        = r_lo;
        n_mcand     = r_mcand;
        n_neg       = r_neg;
        n_cnt       = r_cnt;
        n_rem       = r_rem;
        n_dvsr      = r_dvsr;
        n_err       = r_err;
        n_dt        = r_dt;
        n_sum       = r_sum;
        n_integ     = r_integ;
        n_last_err  = r_last_err;
        n_first     = r_first;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_data  = r_out_data;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_err   = clamp_dw({i_target_value[DW-1], i_target_value}
                                     - {i_measured_value[DW-1], i_measured_value});
                    n_dt    = i_time_step;
                    n_state = S_LOAD;
                end
            end
            S_LOAD: begin
                n_hi    = '0;
                n_lo    = mag_dw(r_gain);
                n_mcand = IW'(mag_dw(r_err));
                n_neg   = r_gain[DW-1] ^ r_err[DW-1];
                n_cnt   = CW'(DW - 1);
                n_phase = PH_P;
                n_state = S_MUL;
            end
            S_MUL: begin
                n_hi  = add_res[IW:1];
                n_lo  = {add_res[0], r_lo[DW-1:1]};
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    if (r_phase == PH_I || r_phase == PH_D) begin
                        n_rem   = '0;
                        n_cnt   = CW'(PW - 1);
                        n_dvsr  = (r_phase == PH_I) ? {1'b0, r_ti} : r_dt;
                        n_state = S_DIV;
                    end else begin
                        n_state = S_FIN;
                    end
                end
            end
            S_DIV: begin
                n_rem = div_ge ? add_res[DW-1:0] : rem_sh[DW-1:0];
                n_hi  = prod_shl[PW-1:DW];
                n_lo  = prod_shl[DW-1:0];
                n_cnt = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                n_hi  = '0;
                n_cnt = CW'(DW - 1);
                case (r_phase)
                    PH_P: begin
                        n_sum = res_dw;
                        if (r_ti != '0) begin
                            n_lo    = mag_dw(r_gain);
                            n_mcand = mag_iw(r_integ);
                            n_neg   = r_gain[DW-1] ^ r_integ[IW-1];
                            n_phase = PH_I;
                            n_state = S_MUL;
                        end else if (d_en) begin
                            n_lo    = mag_dw(r_gain);
                            n_mcand = IW'(r_td);
                            n_neg   = r_gain[DW-1];
                            n_phase = PH_KD;
                            n_state = S_MUL;
                        end else begin
                            n_state = S_SUM;
                        end
                    end
                    PH_I: begin
                        n_sum = clamp_dw({r_sum[DW-1], r_sum} + {res_dw[DW-1], res_dw});
                        if (d_en) begin
                            n_lo    = mag_dw(r_gain);
                            n_mcand = IW'(r_td);
                            n_neg   = r_gain[DW-1];
                            n_phase = PH_KD;
                            n_state = S_MUL;
                        end else begin
                            n_state = S_SUM;
                        end
                    end
                    PH_KD: begin
                        n_lo    = mag_dw(res_dw);
                        n_mcand = IW'(diff_mag);
                        n_neg   = res_dw[DW-1] ^ diff[DW];
                        n_phase = PH_D;
                        n_state = S_MUL;
                    end
                    PH_D: begin
                        n_sum   = clamp_dw({r_sum[DW-1], r_sum} + {res_dw[DW-1], res_dw});
                        n_state = S_SUM;
                    end
                    PH_INC: begin
                        n_integ = clamp_iw({r_integ[IW-1], r_integ} + {res_iw[IW-1], res_iw});
                        n_state = S_DONE;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_SUM: begin
                n_last_err = r_err;
                n_first    = 1'b0;
                if (!pushing) begin
                    n_hi    = '0;
                    n_lo    = mag_dw(r_err);
                    n_mcand = IW'(r_dt);
                    n_neg   = r_err[DW-1];
                    n_cnt   = CW'(DW - 1);
                    n_phase = PH_INC;
                    n_state = S_MUL;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = drive;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_P;
            r_integ     <= '0;
            r_last_err  <= '0;
            r_first     <= 1'b1;
            r_out_valid <= 1'b0;
            r_gain      <= DW'(1) << FRAC_BITS;
            r_ti        <= '0;
            r_td        <= '0;
            r_out_min   <= {1'b1, {(DW-1){1'b0}}};
            r_out_max   <= {1'b0, {(DW-1){1'b1}}};
            r_dead_zone <= '0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_integ     <= n_integ;
            r_last_err  <= n_last_err;
            r_first     <= n_first;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_GAIN:            r_gain      <= i_cfg_data;
                    CFG_INTEGRAL_TIME:   r_ti        <= i_cfg_data[DW-2:0];
                    CFG_DERIVATIVE_TIME: r_td        <= i_cfg_data[DW-2:0];
                    CFG_OUTPUT_MIN:      r_out_min   <= i_cfg_data;
                    CFG_OUTPUT_MAX:      r_out_max   <= i_cfg_data;
                    CFG_DEAD_ZONE:       r_dead_zone <= i_cfg_data[DW-2:0];
                    default: begin
                        r_gain <= r_gain;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_hi       <= n_hi;
        r_lo       <= n_lo;
        r_mcand    <= n_mcand;
        r_neg      <= n_neg;
        r_cnt      <= n_cnt;
        r_rem      <= n_rem;
        r_dvsr     <= n_dvsr;
        r_err      <= n_err;
        r_dt       <= n_dt;
        r_sum      <= n_sum;
        r_out_data <= n_out_data;
    end

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_dvsr != '0 && r_rem < r_dvsr))
        else $error("divider remainder not below divisor");

    a_accept_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_LOAD))
        else $error("accepted word did not start a computation");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result loaded outside completion");

    a_first_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_first) |-> $past(r_state == S_SUM))
        else $error("first-word flag cleared outside summation");

endmodule

// ===== dv/pidaw_checker.sv =====
`timescale 1ns / 1ps

module pidaw_checker #(
    parameter int FRAC_BITS  = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [pidaw_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [DATA_WIDTH-1:0]              i_cfg_data,
    input  logic                               i_in_valid,
    input  logic                               i_in_ready,
    input  logic [DATA_WIDTH-1:0]              i_target_value,
    input  logic [DATA_WIDTH-1:0]              i_measured_value,
    input  logic [DATA_WIDTH-1:0]              i_time_step,
    input  logic                               i_out_valid,
    input  logic                               i_out_ready,
    input  logic [DATA_WIDTH-1:0]              i_drive_value,
    output int                                 o_errors,
    output int                                 o_pending
);
    import pidaw_pkg::*;

    localparam int DW = DATA_WIDTH;
    localparam int IW = DATA_WIDTH + 16;

    longint k_gain;
    longint k_ti;
    longint k_td;
    longint lim_lo;
    longint lim_hi;
    longint dead_band;
    longint prev_err;
    longint integ_acc;
    bit     first_word;

    logic [DW-1:0] drive_q[$];
    int            n_err = 0;

    function automatic logic [127:0] magnitude(longint v);
        logic [63:0] u;
        u = (v < 0) ? 64'(-v) : 64'(v);
        return {64'd0, u};
    endfunction

    function automatic longint clip_mag(bit neg, logic [127:0] m, int w);
        logic [127:0] lim;
        lim = 128'd1 << (w - 1);
        if (neg) begin
            if (m > lim) m = lim;
            return -longint'(m[63:0]);
        end
        if (m >= lim) return longint'(lim[63:0]) - 1;
        return longint'(m[63:0]);
    endfunction

    function automatic longint clip_add(longint a, longint b, int w);
        longint s;
        longint hi;
        longint lo;
        hi = (longint'(1) << (w - 1)) - 1;
        lo = -hi - 1;
        s  = a + b;
        if (s > hi) return hi;
        if (s < lo) return lo;
        return s;
    endfunction

    function automatic logic [DW-1:0] next_drive(longint tgt, longint meas, logic [63:0] dt);
        longint       err;
        longint       p_t;
        longint       i_t;
        longint       d_t;
        longint       kd;
        longint       diff;
        longint       sum;
        longint       inc;
        longint       drv;
        logic [127:0] prod;
        logic [63:0]  bits;
        i_t  = 0;
        d_t  = 0;
        err  = clip_add(tgt, -meas, DW);
        prod = magnitude(k_gain) * magnitude(err);
        p_t  = clip_mag((k_gain < 0) != (err < 0), prod >> FRAC_BITS, DW);
        if (k_ti != 0) begin
            prod = magnitude(k_gain) * magnitude(integ_acc);
            i_t  = clip_mag((k_gain < 0) != (integ_acc < 0), prod / magnitude(k_ti), DW);
        end
        if (!first_word && dt != 0) begin
            prod = magnitude(k_gain) * magnitude(k_td);
            kd   = clip_mag(k_gain < 0, prod >> FRAC_BITS, DW);
            diff = err - prev_err;
            prod = magnitude(kd) * magnitude(diff);
            d_t  = clip_mag((kd < 0) != (diff < 0), prod / {64'd0, dt}, DW);
        end
        first_word = 1'b0;
        prev_err   = err;
        sum = clip_add(clip_add(p_t, i_t, DW), d_t, DW);
        if (!((sum > lim_hi && err > 0) || (sum < lim_lo && err < 0))) begin
            prod      = magnitude(err) * {64'd0, dt};
            inc       = clip_mag(err < 0, prod >> FRAC_BITS, IW);
            integ_acc = clip_add(integ_acc, inc, IW);
        end
        if (magnitude(sum) < magnitude(dead_band)) drv = 0;
        else if (sum < lim_lo) drv = lim_lo;
        else if (sum > lim_hi) drv = lim_hi;
        else drv = sum;
        bits = drv;
        return bits[DW-1:0];
    endfunction

    always @(posedge i_clk) begin
        logic [DW-1:0] want;
        if (!i_rst_n) begin
            k_gain     = longint'(1) << FRAC_BITS;
            k_ti       = 0;
            k_td       = 0;
            lim_lo     = -(longint'(1) << (DW - 1));
            lim_hi     = (longint'(1) << (DW - 1)) - 1;
            dead_band  = 0;
            prev_err   = 0;
            integ_acc  = 0;
            first_word = 1'b1;
            drive_q.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_GAIN:            k_gain    = longint'($signed(i_cfg_data));
                    CFG_INTEGRAL_TIME:   k_ti      = longint'({1'b0, i_cfg_data[DW-2:0]});
                    CFG_DERIVATIVE_TIME: k_td      = longint'({1'b0, i_cfg_data[DW-2:0]});
                    CFG_OUTPUT_MIN:      lim_lo    = longint'($signed(i_cfg_data));
                    CFG_OUTPUT_MAX:      lim_hi    = longint'($signed(i_cfg_data));
                    CFG_DEAD_ZONE:       dead_band = longint'({1'b0, i_cfg_data[DW-2:0]});
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (drive_q.size() == 0) begin
                    $error("drive_value: no word expected, actual %0d", $signed(i_drive_value));
                    n_err++;
                end else begin
                    want = drive_q.pop_front();
                    if (i_drive_value !== want) begin
                        $error("drive_value mismatch: expected %0d, actual %0d",
                               $signed(want), $signed(i_drive_value));
                        n_err++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                drive_q.push_back(next_drive(longint'($signed(i_target_value)),
                                             longint'($signed(i_measured_value)),
                                             {{(64-DW){1'b0}}, i_time_step}));
            end
        end
        o_pending <= drive_q.size();
        o_errors  <= n_err;
    end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import pidaw_pkg::*;

    localparam int          FRAC_BITS = 16;
    localparam int          DW        = 32;
    localparam int          HOLD_LEN  = 3000;
    localparam int          SETTLE    = 400;
    localparam int unsigned LIMIT     = 1500000;

    typedef enum int {
        MIX_MODERATE,
        MIX_CROSSED,
        MIX_WILD
    } t_mix;

    logic          clk;
    logic          rst_n     = 1'b0;
    logic          cfg_wr_en = 1'b0;
    t_cfg_idx      cfg_index = CFG_GAIN;
    logic [DW-1:0] cfg_data  = '0;
    logic          in_valid  = 1'b0;
    logic [DW-1:0] target    = '0;
    logic [DW-1:0] measured  = '0;
    logic [DW-1:0] tstep     = '0;
    logic          out_ready = 1'b0;
    logic          in_ready;
    logic          out_valid;
    logic [DW-1:0] drive;

    int          err_count;
    int          pending;
    int          tx_idle   = 0;
    int          rx_idle   = 0;
    bit          hold_go   = 1'b0;
    bit          hold_ack  = 1'b0;
    int          hold_left = 0;
    int          words_sent = 0;
    int unsigned cycle_cnt = 0;

    pid_controller_antiwindup #(
        .FRAC_BITS  (FRAC_BITS),
        .DATA_WIDTH (DW)
    ) uut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_wr_en      (cfg_wr_en),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_target_value   (target),
        .i_measured_value (measured),
        .i_time_step      (tstep),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_drive_value    (drive)
    );

    pidaw_checker #(
        .FRAC_BITS  (FRAC_BITS),
        .DATA_WIDTH (DW)
    ) u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_wr_en      (cfg_wr_en),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (in_valid),
        .i_in_ready       (in_ready),
        .i_target_value   (target),
        .i_measured_value (measured),
        .i_time_step      (tstep),
        .i_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .i_drive_value    (drive),
        .o_errors         (err_count),
        .o_pending        (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        while (cycle_cnt < LIMIT) begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // hold off the result channel for a long stretch on request
    always @(posedge clk) begin
        if (hold_left > 0) begin
            out_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_go != hold_ack) begin
            out_ready <= 1'b0;
            hold_left <= HOLD_LEN;
            hold_ack  <= hold_go;
        end else begin
            out_ready <= ($urandom_range(99) >= rx_idle);
        end
    end

    function automatic logic [DW-1:0] rand_q16();
        logic [DW-1:0] v;
        if ($urandom_range(3) == 0) return $urandom;
        v = $urandom >> $urandom_range(31, 0);
        if ($urandom_range(1)) v = -v;
        return v;
    endfunction

    function automatic logic [DW-1:0] rand_small();
        logic [DW-1:0] v;
        v = $urandom >> $urandom_range(31, 4);
        if ($urandom_range(1)) v = -v;
        return v;
    endfunction

    function automatic logic [DW-1:0] rand_step();
        case ($urandom_range(9))
            0:       return $urandom;
            1:       return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0000_0001;
            default: return $urandom_range(32'h0002_0000, 32'h0000_0040);
        endcase
    endfunction

    task automatic send_word(input logic [DW-1:0] t, input logic [DW-1:0] m,
                             input logic [DW-1:0] dt);
        while ($urandom_range(99) < tx_idle) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        target   <= t;
        measured <= m;
        tstep    <= dt;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        words_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [DW-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
    endtask

    task automatic load_config(input logic [DW-1:0] g, input logic [DW-1:0] ti,
                               input logic [DW-1:0] td, input logic [DW-1:0] mn,
                               input logic [DW-1:0] mx, input logic [DW-1:0] dz);
        write_reg(CFG_GAIN, g);
        write_reg(CFG_INTEGRAL_TIME, ti);
        write_reg(CFG_DERIVATIVE_TIME, td);
        write_reg(CFG_OUTPUT_MIN, mn);
        write_reg(CFG_OUTPUT_MAX, mx);
        write_reg(CFG_DEAD_ZONE, dz);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic rand_config(input t_mix mix);
        logic [DW-1:0] g;
        logic [DW-1:0] mn;
        logic [DW-1:0] mx;
        if (mix == MIX_WILD) begin
            load_config($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        end else begin
            g  = $urandom_range(32'h0004_0000, 0);
            if ($urandom_range(1)) g = -g;
            mn = -$urandom_range(32'h0400_0000, 32'h0001_0000);
            mx = $urandom_range(32'h0400_0000, 32'h0001_0000);
            if (mix == MIX_CROSSED) begin
                mn = -mn;
                mx = -mx;
            end
            load_config(g, $urandom_range(32'h0008_0000, 32'h100),
                        $urandom_range(32'h0002_0000, 0), mn, mx,
                        $urandom_range(32'h2000, 0));
        end
    endtask

    // settle toward the setpoint with a little noise
    task automatic run_track(input int n);
        longint        tgt;
        longint        meas;
        logic [DW-1:0] dt;
        tgt  = longint'($signed(rand_small()));
        meas = longint'($signed(rand_small()));
        dt   = rand_step();
        repeat (n) begin
            send_word(tgt[DW-1:0], meas[DW-1:0], dt);
            meas = meas + (tgt - meas) / 4 + longint'($urandom_range(512)) - 256;
            if ($urandom_range(9) == 0) dt = rand_step();
        end
    endtask

    task automatic run_phase(input int n, input bit do_hold, input bit do_pause);
        int  start;
        bit  held;
        bit  paused;
        start  = words_sent;
        held   = 1'b0;
        paused = 1'b0;
        while (words_sent - start < n) begin
            if (do_hold && !held && words_sent - start >= n / 4) begin
                hold_go <= ~hold_go;
                held = 1'b1;
            end
            if (do_pause && !paused && words_sent - start >= n / 2) begin
                drain();
                paused = 1'b1;
            end
            if ($urandom_range(9) < 7) run_track($urandom_range(20, 5));
            else send_word(rand_q16(), rand_q16(), rand_step());
        end
        drain();
    endtask

    initial begin
        tx_idle = 34;
        rx_idle <= 60;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(32'h0000_0000, 32'h0000_0000, 32'h0001_0000);
        send_word(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000);
        send_word(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_word(32'h0001_0000, 32'h0000_0000, 32'h0000_0000);
        send_word(32'h0001_0000, 32'h0000_8000, 32'h0000_0001);
        drain();

        load_config(32'h0002_0000, 32'h0001_0000, 32'h0000_8000,
                    32'hFFFB_0000, 32'h0005_0000, 32'h0000_0100);
        repeat (3) send_word(32'h0010_0000, 32'h0000_0000, 32'h0001_0000);
        repeat (2) send_word(32'hFFF0_0000, 32'h0000_0000, 32'h0001_0000);
        send_word(32'h0000_0040, 32'h0000_0000, 32'h0001_0000);
        send_word(32'h0000_1000, 32'h0000_0800, 32'h0000_4000);
        drain();

        load_config(32'h0001_0000, 32'h0000_0000, 32'h0000_0000,
                    32'h0003_0000, 32'hFFFD_0000, 32'h0000_0000);
        send_word(32'h0000_0000, 32'h0001_0000, 32'h0001_0000);
        send_word(32'h0005_0000, 32'h0000_0000, 32'h0001_0000);
        send_word(32'h0002_0000, 32'h0000_0000, 32'h0001_0000);
        drain();

        load_config(32'h8000_0000, 32'h0000_0001, 32'h7FFF_FFFF,
                    32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
        send_word(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0001);
        send_word(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_word(32'h0000_0000, 32'h0000_0000, 32'h0001_0000);
        drain();

        load_config(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0000,
                    32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_word(32'h1234_5678, 32'h0000_0001, 32'h0001_0000);
        send_word(32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000);
        drain();

        rand_config(MIX_MODERATE);
        run_phase(80, 1'b0, 1'b0);
        rand_config(MIX_MODERATE);
        run_phase(80, 1'b1, 1'b0);
        load_config(32'h7FFF_FFFF, 32'h0000_0001, 32'h7FFF_FFFF,
                    32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
        run_phase(80, 1'b0, 1'b0);

        tx_idle = 60;
        rx_idle <= 34;
        rand_config(MIX_WILD);
        run_phase(80, 1'b0, 1'b0);
        rand_config(MIX_CROSSED);
        run_phase(80, 1'b0, 1'b1);
        load_config(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000,
                    32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        run_phase(80, 1'b0, 1'b0);

        tx_idle = 0;
        rx_idle <= 0;
        rand_config(MIX_WILD);
        run_phase(80, 1'b0, 1'b0);
        rand_config(MIX_MODERATE);
        run_phase(80, 1'b0, 1'b0);

        repeat (SETTLE) @(posedge clk);
        if (err_count == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
